>>> rtl/plt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg
// Shared constants, types and reset tables for the transfer function lookup.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned MaxPoints = 16;
  localparam int unsigned ValueBits = 16;

  typedef enum logic [1:0] {
    OP_WR_COLOR   = 2'd0,
    OP_WR_OPACITY = 2'd1,
    OP_QUERY      = 2'd2,
    OP_NOP        = 2'd3
  } opcode_e;

  localparam logic [1:0] CFG_COLOR_COUNT   = 2'd0;
  localparam logic [1:0] CFG_OPACITY_COUNT = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_COUNT  = 2'd2;

  // Jet map in Q0.16: position, red, green, blue.
  function automatic logic [63:0] jet_point(input int unsigned k);
    logic [63:0] p;
    begin
      case (k)
        0: p = {16'd0,     16'd0,     16'd0,     16'd36863};
        1: p = {16'd10923, 16'd0,     16'd0,     16'd65535};
        2: p = {16'd21845, 16'd0,     16'd65535, 16'd65535};
        3: p = {16'd32768, 16'd32769, 16'd65535, 16'd32769};
        4: p = {16'd43691, 16'd65535, 16'd65535, 16'd0};
        5: p = {16'd54613, 16'd65535, 16'd0,     16'd0};
        6: p = {16'd65535, 16'd32769, 16'd0,     16'd0};
        default: p = '0;
      endcase
      return p;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/plt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plt_div #(
  parameter int unsigned NumBits = 32,
  parameter int unsigned DenBits = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0] den_i,
  output logic                    done_o,
  output logic      [NumBits-1:0] quo_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] num_q;
  logic [DenBits-1:0] den_q;
  logic [DenBits:0]   rem_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic [DenBits+1:0] trial;

  assign trial = {rem_q, num_q[NumBits-1]} - {1'b0, 1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(NumBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_o <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (!trial[DenBits+1]) begin
        rem_q <= trial[DenBits:0];
        quo_o <= {quo_o[NumBits-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DenBits-1:0], num_q[NumBits-1]};
        quo_o <= {quo_o[NumBits-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/piecewise_linear_transfer_function_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_transfer_function_top
// Color and opacity transfer function lookup over two control point memories.
// ----------------------------------------------------------------------------
// Point writes leave busy low, so writes can follow back to back.
// A query holds busy through the sample position division (when more than one
// sample), the point reads in each table, one division per interpolated channel
// (four channels) and an output step per table. done marks the result for one
// cycle as busy drops; the next request goes at the following edge. After reset
// an init pass loads the tables, busy high.
module piecewise_linear_transfer_function_top
  import plt_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPoints
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  point_index_i,
  input  wire logic [15:0] position_i,
  input  wire logic [15:0] red_i,
  input  wire logic [15:0] green_i,
  input  wire logic [15:0] blue_i,
  input  wire logic [15:0] alpha_i,
  input  wire logic [11:0] sample_index_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  output logic [15:0]      out_red_o,
  output logic [15:0]      out_green_o,
  output logic [15:0]      out_blue_o,
  output logic [15:0]      out_opacity_o,
  output logic [11:0]      sample_number_o
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_XDIV, S_SCAN, S_SCANW, S_MUL, S_DIV, S_DIVW, S_OUT
  } state_e;

  state_e state_q;
  logic [AW:0] ptr_q;
  logic        tbl_q;          // 0 color, 1 opacity
  logic [1:0]  ch_q;
  logic [4:0]  ccnt_q, ocnt_q;
  logic [12:0] scnt_q;
  logic [11:0] si_q;
  logic [15:0] x_q;
  logic [63:0] prev_q, cur_q;
  logic [15:0] res_q [4];
  logic [39:0] mul_q;
  logic [15:0] w_q;

  // Point memories, one synchronous read port each.
  logic [63:0] cmem [MAX_POINTS];
  logic [31:0] omem [MAX_POINTS];
  logic [63:0] crd_q;
  logic [31:0] ord_q;
  logic [AW-1:0] raddr;
  logic        cwe, owe;
  logic [AW-1:0] waddr;
  logic [63:0] cwd;
  logic [31:0] owd;

  logic accept;
  assign accept = start && !busy;

  always_comb begin
    cwe = 1'b0; owe = 1'b0;
    waddr = AW'(point_index_i);
    cwd = {position_i, red_i, green_i, blue_i};
    owd = {position_i, alpha_i};
    if (state_q == S_INIT) begin
      cwe = 1'b1; owe = 1'b1;
      waddr = ptr_q[AW-1:0];
      cwd = jet_point(32'(ptr_q));
      owd = (ptr_q == '0) ? 32'd0 : (ptr_q == (AW+1)'(1)) ? 32'hFFFF_FFFF : 32'd0;
    end else if (accept && ({28'd0, point_index_i} < 32'(MAX_POINTS))) begin
      cwe = (opcode_i == OP_WR_COLOR);
      owe = (opcode_i == OP_WR_OPACITY);
    end
  end

  assign raddr = ptr_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cwe) cmem[waddr] <= cwd;
    if (owe) omem[waddr] <= owd;
    crd_q <= cmem[raddr];
    ord_q <= omem[raddr];
  end

  // Shared divider: sample position and interpolated channel values.
  logic        dv_start, dv_done;
  logic [39:0] dv_num, dv_quo;
  logic [15:0] dv_den;
  plt_div #(.NumBits(40), .DenBits(16)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  // Scan helpers.
  logic [4:0]  cnt_raw;
  logic [CW-1:0] neff;
  logic [63:0] rd;
  logic [15:0] rpos;
  logic [15:0] d_w, w_w;
  logic [15:0] pv, cv;
  always_comb begin
    cnt_raw = tbl_q ? ocnt_q : ccnt_q;
    if (cnt_raw == 5'd0) neff = CW'(1);
    else if (32'(cnt_raw) > 32'(MAX_POINTS)) neff = CW'(MAX_POINTS);
    else neff = CW'(cnt_raw);
    rd   = tbl_q ? {ord_q[31:16], ord_q[15:0], 32'd0} : crd_q;
    rpos = rd[63:48];
    d_w  = x_q - prev_q[63:48];
    w_w  = cur_q[63:48] - prev_q[63:48];
    case (ch_q)
      2'd0: begin pv = prev_q[47:32]; cv = cur_q[47:32]; end
      2'd1: begin pv = prev_q[31:16]; cv = cur_q[31:16]; end
      default: begin pv = prev_q[15:0]; cv = cur_q[15:0]; end
    endcase
  end

  logic [12:0] sm1;
  assign sm1 = scnt_q - 13'd1;

  logic [1:0] res_base;
  assign res_base = tbl_q ? 2'd3 : 2'd0;
  logic [1:0] last_ch;
  assign last_ch = tbl_q ? 2'd0 : 2'd2;

  always_comb begin
    dv_start = 1'b0; dv_num = '0; dv_den = '0;
    if (accept && opcode_i == OP_QUERY && scnt_q > 13'd1) begin
      dv_start = 1'b1;
      dv_num = {12'd0, sample_index_i, 16'd0};
      dv_den = {3'd0, sm1};
    end else if (state_q == S_DIV) begin
      dv_start = 1'b1;
      dv_num = mul_q + 40'(w_q >> 1);
      dv_den = w_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ptr_q <= '0;
      tbl_q <= 1'b0;
      ch_q <= '0;
      ccnt_q <= 5'd7;
      ocnt_q <= 5'd2;
      scnt_q <= 13'd256;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLOR_COUNT:   ccnt_q <= cfg_data_i[4:0];
          CFG_OPACITY_COUNT: ocnt_q <= cfg_data_i[4:0];
          CFG_SAMPLE_COUNT:  scnt_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_INIT: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == (AW+1)'(MAX_POINTS - 1)) begin
            state_q <= S_IDLE; busy <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept && opcode_i == OP_QUERY) begin
            busy <= 1'b1;
            si_q <= sample_index_i;
            x_q <= '0;
            tbl_q <= 1'b0;
            ptr_q <= '0;
            state_q <= (scnt_q > 13'd1) ? S_XDIV : S_SCANW;
          end
        end
        S_XDIV: begin
          if (dv_done) begin
            x_q <= (dv_quo > 40'hFFFF) ? 16'hFFFF : dv_quo[15:0];
            state_q <= S_SCANW;
          end
        end
        S_SCANW: begin
          // address settles, read lands next cycle
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // rd holds entry ptr_q
          cur_q <= rd;
          if (ptr_q == '0) prev_q <= rd;
          else prev_q <= cur_q;
          if (ptr_q == '0 && x_q <= rpos) begin
            res_q[res_base] <= rd[47:32];
            if (!tbl_q) begin res_q[1] <= rd[31:16]; res_q[2] <= rd[15:0]; end
            state_q <= S_OUT;
          end else if (ptr_q != '0 && x_q <= rpos) begin
            ch_q <= '0;
            state_q <= S_MUL;
          end else if (ptr_q + 1'b1 >= (AW+1)'(neff)) begin
            res_q[res_base] <= rd[47:32];
            if (!tbl_q) begin res_q[1] <= rd[31:16]; res_q[2] <= rd[15:0]; end
            state_q <= S_OUT;
          end else begin
            ptr_q <= ptr_q + 1'b1;
            state_q <= S_SCANW;
          end
        end
        S_MUL: begin
          w_q <= w_w;
          mul_q <= 40'(32'(pv) * 32'(w_w - d_w)) + 40'(32'(cv) * 32'(d_w));
          if (w_w == 16'd0) begin
            res_q[res_base + ch_q] <= pv;
            if (ch_q == last_ch) state_q <= S_OUT;
            else ch_q <= ch_q + 1'b1;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: begin
          if (dv_done) begin
            res_q[res_base + ch_q] <= dv_quo[15:0];
            if (ch_q == last_ch) state_q <= S_OUT;
            else begin ch_q <= ch_q + 1'b1; state_q <= S_MUL; end
          end
        end
        S_OUT: begin
          if (!tbl_q) begin
            tbl_q <= 1'b1; ptr_q <= '0; state_q <= S_SCANW;
          end else begin
            done <= 1'b1; busy <= 1'b0; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_red_o       = res_q[0];
  assign out_green_o     = res_q[1];
  assign out_blue_o      = res_q[2];
  assign out_opacity_o   = res_q[3];
  assign sample_number_o = si_q;

  // Check: a result only follows a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> $past(busy))
    else $error("result without request");
  // Check: no memory write in the scan state of a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !cwe && !owe)
    else $error("point write during scan");
  // Check: busy drops exactly with a result or leaving init.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done || $past(state_q == S_INIT))
    else $error("busy dropped early");
endmodule
`default_nettype wire
